[rtl/core/rhsv_pkg.sv]
// Shared constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
package rhsv_pkg;

  // Default widths of a color component and of the hue angle
  localparam int RHSV_COMPONENT_BITS = 8;
  localparam int RHSV_HUE_BITS       = 16;

  // Extra bits that hold six times a component difference
  localparam int RHSV_SIX_BITS = 3;

endpackage

[rtl/core/rhsv_prep.sv]
// Front end of the RGB to HSV converter: max/min, hexcone sector and
// division operands, in two register stages. Depends on rhsv_pkg.
module rhsv_prep #(
  parameter int COMPONENT_BITS = rhsv_pkg::RHSV_COMPONENT_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 valid_i,
  input  logic [COMPONENT_BITS-1:0]                            red_i,
  input  logic [COMPONENT_BITS-1:0]                            green_i,
  input  logic [COMPONENT_BITS-1:0]                            blue_i,
  output logic                                                 valid_o,
  output logic                                                 grey_o,
  output logic [COMPONENT_BITS-1:0]                            mx_o,
  output logic [COMPONENT_BITS+rhsv_pkg::RHSV_SIX_BITS-1:0]    d6_o,
  output logic [COMPONENT_BITS+rhsv_pkg::RHSV_SIX_BITS-1:0]    num_o,
  output logic [COMPONENT_BITS-1:0]                            x_hi_o,
  output logic [COMPONENT_BITS-1:0]                            x_lo_o
);
  import rhsv_pkg::*;

  localparam int C  = COMPONENT_BITS;
  localparam int DW = COMPONENT_BITS + RHSV_SIX_BITS;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Stage 1 registers
  logic            v1_r;
  logic [C-1:0]    mx1_r, mx1_nxt;
  logic [C-1:0]    dl1_r, dl1_nxt;
  sector_t         sec1_r, sec1_nxt;
  logic            neg1_r, neg1_nxt;
  logic [C-1:0]    mag1_r, mag1_nxt;

  // Stage 2 registers
  logic            v2_r;
  logic            grey2_r, grey2_nxt;
  logic [C-1:0]    mx2_r;
  logic [DW-1:0]   d62_r, d62_nxt;
  logic [DW-1:0]   num2_r, num2_nxt;
  logic [C-1:0]    xhi2_r, xhi2_nxt;
  logic [C-1:0]    xlo2_r, xlo2_nxt;

  logic [C-1:0]    mn;
  logic [DW-1:0]   base;
  logic [DW-1:0]   mag_ext;
  logic [DW:0]     wrap_sum;
  logic [2*C-1:0]  x_full;

  // Find max and min, pick sector by first maximum: red, green, blue
  always_comb begin
    mx1_nxt = red_i;
    mn      = red_i;
    if (green_i > mx1_nxt) mx1_nxt = green_i;
    if (blue_i > mx1_nxt)  mx1_nxt = blue_i;
    if (green_i < mn)      mn      = green_i;
    if (blue_i < mn)       mn      = blue_i;
    dl1_nxt = mx1_nxt - mn;
    if (red_i == mx1_nxt) begin
      sec1_nxt = SEC_RED;
      neg1_nxt = green_i < blue_i;
      mag1_nxt = neg1_nxt ? (blue_i - green_i) : (green_i - blue_i);
    end else if (green_i == mx1_nxt) begin
      sec1_nxt = SEC_GREEN;
      neg1_nxt = blue_i < red_i;
      mag1_nxt = neg1_nxt ? (red_i - blue_i) : (blue_i - red_i);
    end else begin
      sec1_nxt = SEC_BLUE;
      neg1_nxt = red_i < green_i;
      mag1_nxt = neg1_nxt ? (green_i - red_i) : (red_i - green_i);
    end
  end

  // Build hue numerator, six times delta and the saturation dividend
  always_comb begin
    case (sec1_r)
      SEC_GREEN: base = {{(RHSV_SIX_BITS-1){1'b0}}, dl1_r, 1'b0};
      SEC_BLUE:  base = {{(RHSV_SIX_BITS-2){1'b0}}, dl1_r, 2'b00};
      default:   base = '0;
    endcase
    d62_nxt  = {{(RHSV_SIX_BITS-2){1'b0}}, dl1_r, 2'b00}
             + {{(RHSV_SIX_BITS-1){1'b0}}, dl1_r, 1'b0};
    mag_ext  = {{RHSV_SIX_BITS{1'b0}}, mag1_r};
    wrap_sum = {1'b0, base} + {1'b0, d62_nxt} - {1'b0, mag_ext};
    if (!neg1_r) begin
      num2_nxt = base + mag_ext;
    end else if (mag_ext > base) begin
      // add one full turn
      num2_nxt = wrap_sum[DW-1:0];
    end else begin
      num2_nxt = base - mag_ext;
    end
    grey2_nxt = (dl1_r == '0);
    // delta * (2^C - 1)
    x_full   = {dl1_r, {C{1'b0}}} - {{C{1'b0}}, dl1_r};
    xhi2_nxt = x_full[2*C-1:C];
    xlo2_nxt = x_full[C-1:0];
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    mx1_r   <= mx1_nxt;
    dl1_r   <= dl1_nxt;
    sec1_r  <= sec1_nxt;
    neg1_r  <= neg1_nxt;
    mag1_r  <= mag1_nxt;
    grey2_r <= grey2_nxt;
    mx2_r   <= mx1_r;
    d62_r   <= d62_nxt;
    num2_r  <= num2_nxt;
    xhi2_r  <= xhi2_nxt;
    xlo2_r  <= xlo2_nxt;
  end

  assign valid_o = v2_r;
  assign grey_o  = grey2_r;
  assign mx_o    = mx2_r;
  assign d6_o    = d62_r;
  assign num_o   = num2_r;
  assign x_hi_o  = xhi2_r;
  assign x_lo_o  = xlo2_r;

endmodule

[rtl/core/rhsv_div_stage.sv]
// One register stage of the two restoring dividers: one hue quotient bit
// if DO_HUE and one saturation quotient bit if DO_SAT. Depends on rhsv_pkg.
module rhsv_div_stage #(
  parameter int COMPONENT_BITS = rhsv_pkg::RHSV_COMPONENT_BITS,
  parameter int HUE_BITS       = rhsv_pkg::RHSV_HUE_BITS,
  parameter bit DO_HUE         = 1'b1,
  parameter bit DO_SAT         = 1'b1
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              valid_i,
  input  logic                                              grey_i,
  input  logic [COMPONENT_BITS-1:0]                         mx_i,
  input  logic [COMPONENT_BITS+rhsv_pkg::RHSV_SIX_BITS-1:0] d6_i,
  input  logic [COMPONENT_BITS+rhsv_pkg::RHSV_SIX_BITS-1:0] hrem_i,
  input  logic [HUE_BITS-1:0]                               hq_i,
  input  logic [COMPONENT_BITS-1:0]                         srem_i,
  input  logic [COMPONENT_BITS-1:0]                         sxlo_i,
  input  logic [COMPONENT_BITS-1:0]                         sq_i,
  output logic                                              valid_o,
  output logic                                              grey_o,
  output logic [COMPONENT_BITS-1:0]                         mx_o,
  output logic [COMPONENT_BITS+rhsv_pkg::RHSV_SIX_BITS-1:0] d6_o,
  output logic [COMPONENT_BITS+rhsv_pkg::RHSV_SIX_BITS-1:0] hrem_o,
  output logic [HUE_BITS-1:0]                               hq_o,
  output logic [COMPONENT_BITS-1:0]                         srem_o,
  output logic [COMPONENT_BITS-1:0]                         sxlo_o,
  output logic [COMPONENT_BITS-1:0]                         sq_o
);
  import rhsv_pkg::*;

  localparam int C  = COMPONENT_BITS;
  localparam int H  = HUE_BITS;
  localparam int DW = COMPONENT_BITS + RHSV_SIX_BITS;

  logic          valid_r;
  logic          grey_r;
  logic [C-1:0]  mx_r;
  logic [DW-1:0] d6_r;
  logic [DW-1:0] hrem_r, hrem_nxt;
  logic [H-1:0]  hq_r, hq_nxt;
  logic [C-1:0]  srem_r, srem_nxt;
  logic [C-1:0]  sxlo_r, sxlo_nxt;
  logic [C-1:0]  sq_r, sq_nxt;

  logic [DW:0]   h_sh, h_dif;
  logic          h_ge;
  logic [C:0]    s_sh, s_dif;
  logic          s_ge;

  // Shift remainder, compare against divisor, subtract on success
  always_comb begin
    h_sh  = {hrem_i, 1'b0};
    h_ge  = h_sh >= {1'b0, d6_i};
    h_dif = h_sh - {1'b0, d6_i};
    s_sh  = {srem_i, sxlo_i[C-1]};
    s_ge  = s_sh >= {1'b0, mx_i};
    s_dif = s_sh - {1'b0, mx_i};
    if (DO_HUE) begin
      hrem_nxt = h_ge ? h_dif[DW-1:0] : h_sh[DW-1:0];
      hq_nxt   = {hq_i[H-2:0], h_ge};
    end else begin
      hrem_nxt = hrem_i;
      hq_nxt   = hq_i;
    end
    if (DO_SAT) begin
      srem_nxt = s_ge ? s_dif[C-1:0] : s_sh[C-1:0];
      sxlo_nxt = {sxlo_i[C-2:0], 1'b0};
      sq_nxt   = {sq_i[C-2:0], s_ge};
    end else begin
      srem_nxt = srem_i;
      sxlo_nxt = sxlo_i;
      sq_nxt   = sq_i;
    end
  end

  // Hold valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    grey_r <= grey_i;
    mx_r   <= mx_i;
    d6_r   <= d6_i;
    hrem_r <= hrem_nxt;
    hq_r   <= hq_nxt;
    srem_r <= srem_nxt;
    sxlo_r <= sxlo_nxt;
    sq_r   <= sq_nxt;
  end

  assign valid_o = valid_r;
  assign grey_o  = grey_r;
  assign mx_o    = mx_r;
  assign d6_o    = d6_r;
  assign hrem_o  = hrem_r;
  assign hq_o    = hq_r;
  assign srem_o  = srem_r;
  assign sxlo_o  = sxlo_r;
  assign sq_o    = sq_r;

endmodule

[rtl/core/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter, hexcone model, fixed point, fully pipelined.
// A result passes through the front-end register stages, the chain of one-bit
// restoring divider stages and an output register. Throughput: one request per
// cycle; busy stays low. Synchronous active-low reset clears the valid bits.
// Depends on rhsv_pkg, rhsv_prep and rhsv_div_stage.
module rgb_to_hsv_converter_top #(
  parameter int COMPONENT_BITS = rhsv_pkg::RHSV_COMPONENT_BITS,
  parameter int HUE_BITS       = rhsv_pkg::RHSV_HUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      out_valid,
  output logic [HUE_BITS-1:0]       out_hue,
  output logic [COMPONENT_BITS-1:0] out_saturation,
  output logic [COMPONENT_BITS-1:0] out_brightness
);
  import rhsv_pkg::*;

  localparam int C    = COMPONENT_BITS;
  localparam int H    = HUE_BITS;
  localparam int DW   = COMPONENT_BITS + RHSV_SIX_BITS;
  localparam int NSTG = (HUE_BITS > COMPONENT_BITS) ? HUE_BITS : COMPONENT_BITS;

  logic          stg_valid [0:NSTG];
  logic          stg_grey  [0:NSTG];
  logic [C-1:0]  stg_mx    [0:NSTG];
  logic [DW-1:0] stg_d6    [0:NSTG];
  logic [DW-1:0] stg_hrem  [0:NSTG];
  logic [H-1:0]  stg_hq    [0:NSTG];
  logic [C-1:0]  stg_srem  [0:NSTG];
  logic [C-1:0]  stg_sxlo  [0:NSTG];
  logic [C-1:0]  stg_sq    [0:NSTG];

  logic          out_valid_r;
  logic [H-1:0]  out_hue_r, out_hue_nxt;
  logic [C-1:0]  out_sat_r, out_sat_nxt;
  logic [C-1:0]  out_bri_r;

  // Pipeline never stalls
  assign busy = 1'b0;

  // Front end: sector selection and division operands
  rhsv_prep #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start & ~busy),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .valid_o (stg_valid[0]),
    .grey_o  (stg_grey[0]),
    .mx_o    (stg_mx[0]),
    .d6_o    (stg_d6[0]),
    .num_o   (stg_hrem[0]),
    .x_hi_o  (stg_srem[0]),
    .x_lo_o  (stg_sxlo[0])
  );

  assign stg_hq[0] = '0;
  assign stg_sq[0] = '0;

  // Divider chain: one quotient bit per stage for each divider that the stage enables
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    rhsv_div_stage #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .HUE_BITS       (HUE_BITS),
      .DO_HUE         (k < HUE_BITS),
      .DO_SAT         (k < COMPONENT_BITS)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stg_valid[k]),
      .grey_i  (stg_grey[k]),
      .mx_i    (stg_mx[k]),
      .d6_i    (stg_d6[k]),
      .hrem_i  (stg_hrem[k]),
      .hq_i    (stg_hq[k]),
      .srem_i  (stg_srem[k]),
      .sxlo_i  (stg_sxlo[k]),
      .sq_i    (stg_sq[k]),
      .valid_o (stg_valid[k+1]),
      .grey_o  (stg_grey[k+1]),
      .mx_o    (stg_mx[k+1]),
      .d6_o    (stg_d6[k+1]),
      .hrem_o  (stg_hrem[k+1]),
      .hq_o    (stg_hq[k+1]),
      .srem_o  (stg_srem[k+1]),
      .sxlo_o  (stg_sxlo[k+1]),
      .sq_o    (stg_sq[k+1])
    );
  end

  // Drop hue and saturation for grey pixels
  always_comb begin
    out_hue_nxt = stg_grey[NSTG] ? '0 : stg_hq[NSTG];
    out_sat_nxt = stg_grey[NSTG] ? '0 : stg_sq[NSTG];
  end

  // Hold output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_valid[NSTG];
    end
  end

  // Register result fields
  always_ff @(posedge clk) begin
    out_hue_r <= out_hue_nxt;
    out_sat_r <= out_sat_nxt;
    out_bri_r <= stg_mx[NSTG];
  end

  // Unused final remainders and divisor
  logic unused_tail;
  assign unused_tail = ^{stg_d6[NSTG], stg_hrem[NSTG], stg_srem[NSTG], stg_sxlo[NSTG]};

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_brightness = out_bri_r;

endmodule
